// ----- src/rbd_pkg.sv -----
package rbd_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_POP_FRONT  = 4'd2;
  localparam logic [3:0] OP_POP_BACK   = 4'd3;
  localparam logic [3:0] OP_READ_AT    = 4'd4;
  localparam logic [3:0] OP_WRITE_AT   = 4'd5;
  localparam logic [3:0] OP_READ_FRONT = 4'd6;
  localparam logic [3:0] OP_READ_BACK  = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  // Status codes returned with every result.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  // One operation request.
  typedef struct packed {
    logic [3:0]         opcode;
    logic [2:0]         position;
    logic signed [31:0] data_in;
  } rbd_in_t;

  // One operation result.
  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
    logic [3:0]         count;
    logic               is_empty;
    logic               is_full;
  } rbd_out_t;

endpackage

// ----- src/rbd_ram.sv -----
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/ring_buffer_deque_core.sv -----
// Ring-buffer deque: one operation per transfer, one result per operation.
// Pushes, pops, write_at, clear and every rejected operation: the result is
// registered at the input transfer; the next item may follow at once unless the
// result stalls. A successful read first goes through the store's read register.
// Reset (synchronous, active low) empties the deque: head and count go to zero.
// Store contents are not cleared; the count rules never read an unwritten entry.
module ring_buffer_deque_core
  import rbd_pkg::*;
#(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rbd_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = ((CW > 3) ? CW : 3) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r;
  rbd_out_t        out_data_r;

  logic            acc;
  logic            full, empty, in_range;
  logic [CW-1:0]   logical;
  logic [SW-1:0]   slot_sum;
  logic [AW-1:0]   slot;
  logic [AW-1:0]   head_dec;
  logic [1:0]      status;
  logic            is_read;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [31:0]     rd_ext;

  // Take a new item only when idle and the result register can be filled.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign in_range = SW'(in_data.position) < SW'(count_r);

  // Logical index from the front that this operation addresses.
  always_comb begin
    case (in_data.opcode)
      OP_PUSH_BACK: logical = count_r;
      OP_READ_AT:   logical = CW'(in_data.position);
      OP_WRITE_AT:  logical = CW'(in_data.position);
      OP_READ_BACK: logical = count_r - CW'(1);
      OP_POP_FRONT: logical = CW'(1);
      default:      logical = '0;
    endcase
  end

  // Physical slot: head plus logical index, wrapped once around the capacity.
  always_comb begin
    slot_sum = SW'(head_r) + SW'(logical);
    if (slot_sum >= SW'(CAPACITY)) begin
      slot_sum = slot_sum - SW'(CAPACITY);
    end
    slot = slot_sum[AW-1:0];
  end

  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);

  // Keep the low input bits (zero-filled above bit 31); sign-extend the read word.
  genvar gi;
  generate
    for (gi = 0; gi < DATA_WIDTH; gi++) begin : g_wr
      if (gi < 32) begin : g_bit
        assign wr_data[gi] = in_data.data_in[gi];
      end else begin : g_zero
        assign wr_data[gi] = 1'b0;
      end
    end
    for (gi = 0; gi < 32; gi++) begin : g_rd
      if (gi < DATA_WIDTH) begin : g_bit
        assign rd_ext[gi] = rd_data[gi];
      end else begin : g_sign
        assign rd_ext[gi] = rd_data[DATA_WIDTH-1];
      end
    end
  endgenerate

  // Decode the operation against the current head and count.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = STS_OK;
    is_read   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = slot;
    case (in_data.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = STS_FULL;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
          wr_en     = 1'b1;
          wr_addr   = head_dec;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = STS_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          wr_en     = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = STS_EMPTY;
        end else begin
          head_nxt  = slot;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = STS_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ_AT: begin
        if (!in_range) begin
          status = STS_RANGE;
        end else begin
          is_read = 1'b1;
        end
      end
      OP_WRITE_AT: begin
        if (!in_range) begin
          status = STS_RANGE;
        end else begin
          wr_en = 1'b1;
        end
      end
      OP_READ_FRONT, OP_READ_BACK: begin
        if (empty) begin
          status = STS_EMPTY;
        end else begin
          is_read = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (acc && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (acc && is_read),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  // A successful read waits in ST_READ for the store.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc && is_read) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= !is_read;
      end else if (state_r == ST_READ) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (acc && !is_read) begin
      out_data_r.read_data <= '0;
      out_data_r.status    <= status;
      out_data_r.count     <= 4'(count_nxt);
      out_data_r.is_empty  <= (count_nxt == '0);
      out_data_r.is_full   <= (count_nxt == CW'(CAPACITY));
    end else if (state_r == ST_READ) begin
      out_data_r.read_data <= rd_ext;
      out_data_r.status    <= STS_OK;
      out_data_r.count     <= 4'(count_r);
      out_data_r.is_empty  <= empty;
      out_data_r.is_full   <= full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/rbd_checker.sv -----
module rbd_checker
  import rbd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input rbd_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input rbd_out_t out_data
);

  // A stalled result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.count == 4'd0)))
    else $error("empty flag disagrees with count");

  // A rejected operation never returns data.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STS_OK) |-> (out_data.read_data == '0))
    else $error("rejected operation returned data");

  // A full rejection is reported only while the deque is full.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STS_FULL) |-> out_data.is_full)
    else $error("full rejection without full flag");

  // A clear answers in the next cycle with an empty deque.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == OP_CLEAR)
      |=> out_valid && (out_data.count == 4'd0) && out_data.is_empty)
    else $error("clear did not empty the deque");

endmodule

bind ring_buffer_deque_core rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/tb_ring_buffer_deque_core.sv -----
`timescale 1ns / 1ps

module tb_ring_buffer_deque_core;
  import rbd_pkg::*;

  localparam int DEPTH = 8;
  localparam int RANDOM_OPS = 600;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;

  // Highest opcode value; everything above OP_CLEAR is a no-op.
  localparam logic [3:0] OP_LAST_CODE = 4'hF;

  // Where a directed row takes its expected result from.
  localparam logic WANT_TYPED = 1'b1;
  localparam logic WANT_PREDICTED = 1'b0;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} fill_mode_e;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_e;

  typedef struct packed {
    rbd_in_t  req;
    logic     typed;
    rbd_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rbd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rbd_out_t out_data;

  // Shadow copy of the deque that predicts each result.
  logic signed [31:0] deque_store [DEPTH];
  logic [2:0]         deque_head;
  logic [3:0]         deque_count;

  rbd_out_t pending_results [$];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;

  // Directed opening: empty and range rejections, the data extremes, fill to full,
  // rejected pushes, an unused opcode and a clear.
  stim_row_t directed_rows [25] = '{
    '{'{OP_READ_FRONT, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_EMPTY, 4'd0, 1'b1, 1'b0}},
    '{'{OP_POP_BACK, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_EMPTY, 4'd0, 1'b1, 1'b0}},
    '{'{OP_POP_FRONT, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_EMPTY, 4'd0, 1'b1, 1'b0}},
    '{'{OP_READ_BACK, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_EMPTY, 4'd0, 1'b1, 1'b0}},
    '{'{OP_READ_AT, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_RANGE, 4'd0, 1'b1, 1'b0}},
    '{'{OP_WRITE_AT, 3'd7, 32'h0F0F_0F0F}, WANT_TYPED,
      '{32'h0000_0000, STS_RANGE, 4'd0, 1'b1, 1'b0}},
    '{'{OP_PUSH_BACK, 3'd0, 32'h7FFF_FFFF}, WANT_TYPED,
      '{32'h0000_0000, STS_OK, 4'd1, 1'b0, 1'b0}},
    '{'{OP_PUSH_FRONT, 3'd0, 32'h8000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_OK, 4'd2, 1'b0, 1'b0}},
    '{'{OP_READ_FRONT, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h8000_0000, STS_OK, 4'd2, 1'b0, 1'b0}},
    '{'{OP_READ_BACK, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h7FFF_FFFF, STS_OK, 4'd2, 1'b0, 1'b0}},
    '{'{OP_PUSH_BACK, 3'd5, 32'hFFFF_FFFF}, WANT_PREDICTED, '0},
    '{'{OP_PUSH_FRONT, 3'd2, 32'h0000_0000}, WANT_PREDICTED, '0},
    '{'{OP_PUSH_BACK, 3'd0, 32'h5555_5555}, WANT_PREDICTED, '0},
    '{'{OP_PUSH_FRONT, 3'd7, 32'hAAAA_AAAA}, WANT_PREDICTED, '0},
    '{'{OP_PUSH_BACK, 3'd0, 32'h0000_0001}, WANT_PREDICTED, '0},
    '{'{OP_PUSH_FRONT, 3'd0, 32'h1234_5678}, WANT_TYPED,
      '{32'h0000_0000, STS_OK, 4'd8, 1'b0, 1'b1}},
    '{'{OP_PUSH_BACK, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_FULL, 4'd8, 1'b0, 1'b1}},
    '{'{OP_PUSH_FRONT, 3'd0, 32'hFFFF_FFFF}, WANT_TYPED,
      '{32'h0000_0000, STS_FULL, 4'd8, 1'b0, 1'b1}},
    '{'{OP_READ_AT, 3'd7, 32'h0000_0000}, WANT_PREDICTED, '0},
    '{'{OP_WRITE_AT, 3'd3, 32'hDEAD_BEEF}, WANT_PREDICTED, '0},
    '{'{OP_READ_AT, 3'd3, 32'h0000_0000}, WANT_PREDICTED, '0},
    '{'{OP_LAST_CODE, 3'd7, 32'hFFFF_FFFF}, WANT_TYPED,
      '{32'h0000_0000, STS_OK, 4'd8, 1'b0, 1'b1}},
    '{'{OP_POP_FRONT, 3'd0, 32'h0000_0000}, WANT_PREDICTED, '0},
    '{'{OP_READ_AT, 3'd7, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_RANGE, 4'd7, 1'b0, 1'b0}},
    '{'{OP_CLEAR, 3'd0, 32'h0000_0000}, WANT_TYPED,
      '{32'h0000_0000, STS_OK, 4'd0, 1'b1, 1'b0}}
  };

  ring_buffer_deque_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Physical slot of a logical index; the 3-bit sum wraps around the ring.
  function automatic logic [2:0] slot_at(input logic [2:0] idx);
    return deque_head + idx;
  endfunction

  // Applies one operation to the shadow deque and returns the result it should give.
  function automatic rbd_out_t apply_deque_op(input rbd_in_t req);
    rbd_out_t res;
    res = '0;
    res.status = STS_OK;
    case (req.opcode)
      OP_PUSH_FRONT: begin
        if (deque_count == DEPTH) begin
          res.status = STS_FULL;
        end else begin
          deque_head = deque_head - 3'd1;
          deque_store[deque_head] = req.data_in;
          deque_count = deque_count + 4'd1;
        end
      end
      OP_PUSH_BACK: begin
        if (deque_count == DEPTH) begin
          res.status = STS_FULL;
        end else begin
          deque_store[slot_at(deque_count[2:0])] = req.data_in;
          deque_count = deque_count + 4'd1;
        end
      end
      OP_POP_FRONT: begin
        if (deque_count == 0) begin
          res.status = STS_EMPTY;
        end else begin
          deque_head = deque_head + 3'd1;
          deque_count = deque_count - 4'd1;
        end
      end
      OP_POP_BACK: begin
        if (deque_count == 0) res.status = STS_EMPTY;
        else deque_count = deque_count - 4'd1;
      end
      OP_READ_AT: begin
        if (req.position >= deque_count) res.status = STS_RANGE;
        else res.read_data = deque_store[slot_at(req.position)];
      end
      OP_WRITE_AT: begin
        if (req.position >= deque_count) res.status = STS_RANGE;
        else deque_store[slot_at(req.position)] = req.data_in;
      end
      OP_READ_FRONT: begin
        if (deque_count == 0) res.status = STS_EMPTY;
        else res.read_data = deque_store[slot_at(3'd0)];
      end
      OP_READ_BACK: begin
        if (deque_count == 0) res.status = STS_EMPTY;
        else res.read_data = deque_store[slot_at(3'(deque_count - 4'd1))];
      end
      OP_CLEAR: begin
        deque_head = '0;
        deque_count = '0;
      end
      default: begin
      end
    endcase
    res.count = deque_count;
    res.is_empty = (deque_count == 0);
    res.is_full = (deque_count == DEPTH);
    return res;
  endfunction

  // Picks a random operation; the mode tilts the mix toward filling or draining.
  function automatic rbd_in_t random_op(input fill_mode_e mode);
    rbd_in_t req;
    int      roll;
    int      push_pct;
    int      pop_pct;
    roll = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 10 : 30;
    pop_pct = (mode == MODE_DRAIN) ? 55 : (mode == MODE_FILL) ? 10 : 30;
    if (roll < 3) req.opcode = 4'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE));
    else if (roll < 5) req.opcode = OP_CLEAR;
    else if (roll < 5 + push_pct)
      req.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else if (roll < 5 + push_pct + pop_pct)
      req.opcode = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    else begin
      case ($urandom_range(0, 3))
        0: req.opcode = OP_READ_AT;
        1: req.opcode = OP_WRITE_AT;
        2: req.opcode = OP_READ_FRONT;
        default: req.opcode = OP_READ_BACK;
      endcase
    end
    // Mostly a legal index, sometimes any index to hit the range check.
    if (deque_count != 0 && $urandom_range(0, 3) != 0)
      req.position = 3'($urandom_range(0, deque_count - 1));
    else
      req.position = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 15))
      0: req.data_in = 32'h7FFF_FFFF;
      1: req.data_in = 32'h8000_0000;
      2: req.data_in = '0;
      3: req.data_in = '1;
      default: req.data_in = $urandom;
    endcase
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Sends one operation, called at a falling edge. Bursts end in random gaps,
  // and the expected result is queued at the edge where the transfer happens.
  task automatic send_op(input rbd_in_t req, input logic typed, input rbd_out_t want);
    rbd_out_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predicted = apply_deque_op(req);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Receiver stall, switching between open, light, heavy and periodic patterns.
  initial begin
    rx_pattern_e pattern;
    int          pattern_left;
    int          phase;
    out_stall = 1'b0;
    pattern = RX_OPEN;
    pattern_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (pattern_left == 0) begin
        pattern = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 80);
      end
      pattern_left--;
      phase++;
      case (pattern)
        RX_OPEN: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((phase % 7) < 3);
      endcase
    end
  end

  // Result checker: every transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    rbd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no operation pending", out_data.read_data, '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.count !== want.count)
          report_mismatch("count", 32'(out_data.count), 32'(want.count));
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
        if (out_data.is_full !== want.is_full)
          report_mismatch("is_full", 32'(out_data.is_full), 32'(want.is_full));
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed rows, then the random stream, then drain.
  initial begin
    rbd_in_t    req;
    fill_mode_e mode;
    int         mode_left;
    int         random_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    deque_head = '0;
    deque_count = '0;
    mode = MODE_MIX;
    mode_left = 0;
    random_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // Unused opcodes are noise and do not count toward the random total.
    while (random_done < RANDOM_OPS) begin
      if (mode_left == 0) begin
        mode = fill_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 24);
      end
      mode_left--;
      req = random_op(mode);
      if (req.opcode <= OP_CLEAR) random_done++;
      send_op(req, WANT_PREDICTED, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("operations left without a result", pending_results.size(), '0);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
